/* hdl/b64h_pkg.sv */
// Shared types and constants for the base64url-to-hex decoder.
// No dependencies.
package b64h_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned ACC_W  = 12;
    localparam int unsigned PEND_W = 3;
    localparam int unsigned SEXT_W = 6;

    localparam logic [CHAR_W-1:0] CHAR_PAD = 8'h3D;  // '='

    // One queued job for the back end: a decoded byte and/or end of string.
    typedef struct packed {
        logic [CHAR_W-1:0] data_byte;
        logic              has_byte;
        logic              last;
    } b64h_job_t;

    // Lower-case ASCII hex digit for a nibble.
    function automatic logic [CHAR_W-1:0] hex_ascii(input logic [3:0] nib);
        logic [CHAR_W-1:0] res;
        if (nib < 4'd10) begin
            res = 8'h30 + {4'd0, nib};
        end else begin
            res = 8'h61 + {4'd0, nib} - 8'd10;
        end
        return res;
    endfunction

endpackage

/* hdl/b64h_front.sv */
// Front end: accepts characters, decodes sextets, keeps the bit accumulator,
// and pushes byte / end jobs into the queue. Depends on b64h_pkg.
module b64h_front import b64h_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CHAR_W-1:0] s_text_char,
    input  logic              s_end_of_text,
    input  logic              q_full,
    output logic              q_push,
    output b64h_job_t         q_job
);

    logic [ACC_W-1:0]  acc_reg,  acc_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              stopped_reg, stopped_next;

    logic              accept;
    logic              sx_ok;
    logic [SEXT_W-1:0] sx;
    logic [ACC_W-1:0]  acc_new;
    logic [3:0]        bits;
    logic [ACC_W-1:0]  shifted;
    logic              is_pad;
    logic              decoding;
    logic              has_byte;

    always_comb begin
        sx_ok = 1'b1;
        sx    = '0;
        priority if (s_text_char >= 8'h41 && s_text_char <= 8'h5A) begin
            sx = SEXT_W'(s_text_char - 8'h41);
        end else if (s_text_char >= 8'h61 && s_text_char <= 8'h7A) begin
            sx = SEXT_W'(s_text_char - 8'h61 + 8'd26);
        end else if (s_text_char >= 8'h30 && s_text_char <= 8'h39) begin
            sx = SEXT_W'(s_text_char - 8'h30 + 8'd52);
        end else if (s_text_char == 8'h2B || s_text_char == 8'h2D) begin
            sx = 6'd62;
        end else if (s_text_char == 8'h2F || s_text_char == 8'h5F) begin
            sx = 6'd63;
        end else begin
            sx_ok = 1'b0;
        end
    end

    assign acc_new  = {acc_reg[ACC_W-SEXT_W-1:0], sx};
    assign bits     = {1'b0, pend_reg} + 4'd6;
    assign has_byte = bits >= 4'd8;
    assign shifted  = acc_new >> (bits - 4'd8);
    assign is_pad   = s_text_char == CHAR_PAD;
    assign decoding = !stopped_reg && !is_pad && sx_ok;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign q_push          = accept && (s_end_of_text || (decoding && has_byte));
    assign q_job.data_byte = shifted[CHAR_W-1:0];
    assign q_job.has_byte  = decoding && has_byte;
    assign q_job.last      = s_end_of_text;

    always_comb begin
        acc_next     = acc_reg;
        pend_next    = pend_reg;
        stopped_next = stopped_reg;
        if (accept) begin
            if (s_end_of_text) begin
                acc_next     = '0;
                pend_next    = '0;
                stopped_next = 1'b0;
            end else if (!stopped_reg && is_pad) begin
                stopped_next = 1'b1;
            end else if (decoding) begin
                acc_next  = acc_new;
                pend_next = bits[PEND_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            pend_reg    <= '0;
            stopped_reg <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            pend_reg    <= pend_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

/* hdl/b64h_queue.sv */
// Small register FIFO of jobs between front and back end.
// Depends on b64h_pkg.
module b64h_queue import b64h_pkg::*; #(
    parameter int unsigned DEPTH = 2
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  b64h_job_t push_job,
    input  logic      pop,
    output b64h_job_t head_job,
    output logic      full,
    output logic      empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    b64h_job_t         mem_reg [DEPTH];
    logic [AW-1:0]     wr_reg, wr_next;
    logic [AW-1:0]     rd_reg, rd_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full     = cnt_reg == CW'(DEPTH);
    assign empty    = cnt_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem_reg[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wr_next = (wr_reg == LAST_IDX) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_next = (rd_reg == LAST_IDX) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_job;
        end
    end

endmodule

/* hdl/b64h_back.sv */
// Back end: turns queued jobs into hex characters or bare end markers,
// one per cycle while jobs are queued and m_ready allows, through an output register. Depends on b64h_pkg.
module b64h_back import b64h_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  b64h_job_t         q_head,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_hex_char,
    output logic              m_char_valid,
    output logic              m_end_of_output
);

    typedef enum logic [1:0] {
        PH_HIGH = 2'b01,
        PH_LOW  = 2'b10
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic              valid_reg, valid_next;
    logic [CHAR_W-1:0] hex_reg, hex_next;
    logic              cv_reg, cv_next;
    logic              eo_reg, eo_next;
    logic              load;

    assign load = !q_empty && (!valid_reg || m_ready);

    always_comb begin
        phase_next = phase_reg;
        valid_next = valid_reg && !m_ready;
        hex_next   = hex_reg;
        cv_next    = cv_reg;
        eo_next    = eo_reg;
        q_pop      = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            if (!q_head.has_byte) begin
                hex_next = '0;
                cv_next  = 1'b0;
                eo_next  = 1'b1;
                q_pop    = 1'b1;
            end else begin
                unique case (phase_reg)
                    PH_HIGH: begin
                        hex_next   = hex_ascii(q_head.data_byte[7:4]);
                        cv_next    = 1'b1;
                        eo_next    = 1'b0;
                        phase_next = PH_LOW;
                    end
                    PH_LOW: begin
                        hex_next   = hex_ascii(q_head.data_byte[3:0]);
                        cv_next    = 1'b1;
                        eo_next    = q_head.last;
                        phase_next = PH_HIGH;
                        q_pop      = 1'b1;
                    end
                    default: begin
                        phase_next = PH_HIGH;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HIGH;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hex_reg <= hex_next;
        cv_reg  <= cv_next;
        eo_reg  <= eo_next;
    end

    assign m_valid         = valid_reg;
    assign m_hex_char      = hex_reg;
    assign m_char_valid    = cv_reg;
    assign m_end_of_output = eo_reg;

endmodule

/* hdl/base64url_to_hex_decoder_top.sv */
// Top level of the base64url-to-hex decoder: front end, job queue, back end.
// Depends on b64h_pkg, b64h_front, b64h_queue, b64h_back.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    s_text_char, s_end_of_text
//   m_       out        m_valid/m_ready    m_hex_char, m_char_valid, m_end_of_output
//
// Front takes one character per cycle while the job queue has room.
// Back gives one result per cycle while m_ready is high and the queue is not
// empty; a character producing a byte yields two results (high, then low digit).
// First result is registered into the queue, then into the output register, before m_valid rises.
// Reset (synchronous, active low) clears accumulator, queue and output valid.
module base64url_to_hex_decoder_top import b64h_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CHAR_W-1:0] s_text_char,
    input  logic              s_end_of_text,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_hex_char,
    output logic              m_char_valid,
    output logic              m_end_of_output
);

    logic      q_full, q_empty, q_push, q_pop;
    b64h_job_t q_in, q_head;

    b64h_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_text_char  (s_text_char),
        .s_end_of_text(s_end_of_text),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (q_in)
    );

    b64h_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_job(q_in),
        .pop     (q_pop),
        .head_job(q_head),
        .full    (q_full),
        .empty   (q_empty)
    );

    b64h_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hex_char     (m_hex_char),
        .m_char_valid   (m_char_valid),
        .m_end_of_output(m_end_of_output)
    );

endmodule

/* tb/sv/b64h_hex_checker.sv */
// Scoreboard for the base64url-to-hex decoder: follows both channels, predicts
// the hex output of every accepted character and compares it in order.
// Depends on b64h_pkg.
module b64h_hex_checker import b64h_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [CHAR_W-1:0] s_text_char,
    input  logic              s_end_of_text,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [CHAR_W-1:0] m_hex_char,
    input  logic              m_char_valid,
    input  logic              m_end_of_output,
    output int                fail_count,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CHAR_W-1:0] hex_char;
        logic              char_valid;
        logic              end_of_output;
    } hex_result_t;

    hex_result_t       hex_expected_q[$];
    logic [ACC_W-1:0]  acc_bits;
    logic [PEND_W-1:0] pend_count;
    logic              pad_seen;

    function automatic int sextet_value(input logic [CHAR_W-1:0] c);
        int v;
        v = -1;
        if (c >= "A" && c <= "Z") begin
            v = int'(c) - int'("A");
        end else if (c >= "a" && c <= "z") begin
            v = int'(c) - int'("a") + 26;
        end else if (c >= "0" && c <= "9") begin
            v = int'(c) - int'("0") + 52;
        end else if (c == "+" || c == "-") begin
            v = 62;
        end else if (c == "/" || c == "_") begin
            v = 63;
        end
        return v;
    endfunction

    function automatic logic [CHAR_W-1:0] nibble_ascii(input logic [3:0] nib);
        return (nib < 4'd10) ? (8'h30 + 8'(nib)) : (8'h57 + 8'(nib));
    endfunction

    task automatic decode_char(input logic [CHAR_W-1:0] c, input logic is_last);
        int          v;
        int          nbits;
        logic [7:0]  data_byte;
        hex_result_t hi_res;
        hex_result_t lo_res;
        logic        made_byte;
        made_byte = 1'b0;
        if (!pad_seen) begin
            if (c == CHAR_PAD) begin
                pad_seen = 1'b1;
            end else begin
                v = sextet_value(c);
                if (v >= 0) begin
                    nbits    = int'(pend_count) + 6;
                    acc_bits = {acc_bits[ACC_W-SEXT_W-1:0], 6'(v)};
                    if (nbits >= 8) begin
                        data_byte = 8'(acc_bits >> (nbits - 8));
                        hi_res    = '{nibble_ascii(data_byte[7:4]), 1'b1, 1'b0};
                        lo_res    = '{nibble_ascii(data_byte[3:0]), 1'b1, is_last};
                        hex_expected_q.insert(hex_expected_q.size(), hi_res);
                        hex_expected_q.insert(hex_expected_q.size(), lo_res);
                        made_byte = 1'b1;
                        nbits -= 8;
                    end
                    pend_count = PEND_W'(nbits);
                end
            end
        end
        if (is_last) begin
            if (!made_byte) begin
                hex_expected_q.insert(hex_expected_q.size(), '{8'h00, 1'b0, 1'b1});
            end
            acc_bits   = '0;
            pend_count = '0;
            pad_seen   = 1'b0;
        end
    endtask

    task automatic note_failure(input string what, input hex_result_t exp_res);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s: expected hex %02h valid %0b end %0b, got hex %02h valid %0b end %0b",
                     $realtime, what, exp_res.hex_char, exp_res.char_valid,
                     exp_res.end_of_output, m_hex_char, m_char_valid, m_end_of_output);
        end
    endtask

    initial begin
        fail_count  = 0;
        outstanding = 0;
        acc_bits    = '0;
        pend_count  = '0;
        pad_seen    = 1'b0;
    end

    always @(posedge aclk) begin
        hex_result_t exp_res;
        if (!aresetn) begin
            acc_bits   = '0;
            pend_count = '0;
            pad_seen   = 1'b0;
            hex_expected_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                decode_char(s_text_char, s_end_of_text);
            end
            if (m_valid && m_ready) begin
                if (hex_expected_q.size() == 0) begin
                    note_failure("unexpected transaction", '0);
                end else begin
                    exp_res = hex_expected_q.pop_front();
                    if (m_hex_char !== exp_res.hex_char || m_char_valid !== exp_res.char_valid
                            || m_end_of_output !== exp_res.end_of_output) begin
                        note_failure("mismatch", exp_res);
                    end
                end
            end
        end
        outstanding = hex_expected_q.size();
    end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top for the base64url-to-hex decoder: clock, reset, character
// stimulus, output back-pressure and the final verdict.
// Depends on b64h_pkg, base64url_to_hex_decoder_top and b64h_hex_checker.
module tb_top import b64h_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TEXT_ITEMS = 1050;
    localparam int CALM_TAIL  = 150;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [CHAR_W-1:0] s_text_char;
    logic              s_end_of_text;
    logic              m_valid;
    logic              m_ready;
    logic [CHAR_W-1:0] m_hex_char;
    logic              m_char_valid;
    logic              m_end_of_output;
    int                fail_count;
    int                outstanding;
    bit                calm;
    int                content_sent;

    base64url_to_hex_decoder_top u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_text_char     (s_text_char),
        .s_end_of_text   (s_end_of_text),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hex_char      (m_hex_char),
        .m_char_valid    (m_char_valid),
        .m_end_of_output (m_end_of_output)
    );

    b64h_hex_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_text_char     (s_text_char),
        .s_end_of_text   (s_end_of_text),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hex_char      (m_hex_char),
        .m_char_valid    (m_char_valid),
        .m_end_of_output (m_end_of_output),
        .fail_count      (fail_count),
        .outstanding     (outstanding)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    task automatic send_char(input logic [CHAR_W-1:0] c, input logic is_last);
        int gap;
        gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_text_char   <= c;
        s_end_of_text <= is_last;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_text(input logic [CHAR_W-1:0] chars[$]);
        for (int i = 0; i < chars.size(); i++) begin
            send_char(chars[i], i == chars.size() - 1);
        end
    endtask

    task automatic send_str(input string t);
        logic [CHAR_W-1:0] chars[$];
        for (int i = 0; i < t.len(); i++) begin
            chars.insert(chars.size(), t[i]);
        end
        send_text(chars);
    endtask

    function automatic logic [CHAR_W-1:0] alpha_char(input int unsigned v);
        logic [CHAR_W-1:0] c;
        if (v < 26) begin
            c = 8'("A" + v);
        end else if (v < 52) begin
            c = 8'("a" + v - 26);
        end else if (v < 62) begin
            c = 8'("0" + v - 52);
        end else if (v == 62) begin
            c = $urandom_range(0, 1) ? "-" : "+";
        end else begin
            c = $urandom_range(0, 1) ? "_" : "/";
        end
        return c;
    endfunction

    // mostly well-formed padded text; some with junk bytes or an early pad
    task automatic send_random_text();
        logic [CHAR_W-1:0] chars[$];
        int unsigned       len;
        int unsigned       kind;
        kind = $urandom_range(0, 19);
        len  = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
        for (int unsigned i = 0; i < len; i++) begin
            chars.insert(chars.size(), alpha_char($urandom_range(0, 63)));
        end
        if (kind < 15) begin
            if ($urandom_range(0, 3) != 0) begin
                if (len % 4 == 2) begin
                    chars.insert(chars.size(), CHAR_PAD);
                    chars.insert(chars.size(), CHAR_PAD);
                end else if (len % 4 == 3) begin
                    chars.insert(chars.size(), CHAR_PAD);
                end
            end
        end else if (kind < 18) begin
            repeat ($urandom_range(1, 3)) begin
                chars.insert($urandom_range(0, chars.size()), 8'($urandom_range(0, 255)));
            end
        end else begin
            chars.insert($urandom_range(0, chars.size()), CHAR_PAD);
            repeat ($urandom_range(0, 4)) begin
                chars.insert(chars.size(), 8'($urandom_range(0, 255)));
            end
        end
        content_sent += int'(chars.size());
        send_text(chars);
    endtask

    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #1_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        s_valid       = 1'b0;
        s_text_char   = '0;
        s_end_of_text = 1'b0;
        aresetn       = 1'b0;
        calm          = 1'b0;
        content_sent  = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_str("AAAA");
        send_str("____");
        send_str("-+/");
        send_str("Q");
        send_str("=");
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b0);
        send_char(8'h80, 1'b0);
        send_str("zZ9");
        send_str("A=B");
        send_str("0a");

        while (content_sent < TEXT_ITEMS) begin
            if (content_sent >= TEXT_ITEMS - CALM_TAIL) begin
                calm = 1'b1;
            end
            send_random_text();
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
